/* rtl/core/stok_pkg.sv */
// stok_pkg: shared types, codes and lookup functions for the source tokenizer
// used by stok_step, stok_outq and source_tokenizer_core; depends on nothing
package stok_pkg;

	localparam int LINE_BITS_DEF   = 16;
	localparam int COLUMN_BITS_DEF = 16;
	localparam int POS_OUT_BITS    = 16;
	localparam int MAX_RES         = 3;
	localparam int PREFIX_LEN      = 5;

	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_IDENT,
		MODE_NUMBER,
		MODE_STRING,
		MODE_ESCAPE,
		MODE_HALT
	} mode_t;

	typedef enum logic [1:0] {
		EV_VALUE,
		EV_DONE,
		EV_ERROR,
		EV_END
	} ev_t;

	typedef enum logic [2:0] {
		ERR_NONE,
		ERR_UNKNOWN,
		ERR_BAD_ESC,
		ERR_END_ESC,
		ERR_UNTERM
	} err_t;

	localparam logic [4:0] TT_IDENT   = 5'd0;
	localparam logic [4:0] TT_LET     = 5'd1;
	localparam logic [4:0] TT_IF      = 5'd2;
	localparam logic [4:0] TT_ELIF    = 5'd3;
	localparam logic [4:0] TT_ELSE    = 5'd4;
	localparam logic [4:0] TT_FN      = 5'd5;
	localparam logic [4:0] TT_USE     = 5'd6;
	localparam logic [4:0] TT_BOOL    = 5'd7;
	localparam logic [4:0] TT_NULL    = 5'd8;
	localparam logic [4:0] TT_LOOP    = 5'd9;
	localparam logic [4:0] TT_STR     = 5'd10;
	localparam logic [4:0] TT_NUM     = 5'd11;
	localparam logic [4:0] TT_OP_BASE = 5'd12;

	typedef logic [PREFIX_LEN-1:0][7:0] kw_prefix_t;

	typedef struct packed {
		ev_t                     ev;
		logic [4:0]              token_type;
		logic [7:0]              value_byte;
		err_t                    err;
		logic [POS_OUT_BITS-1:0] line;
		logic [POS_OUT_BITS-1:0] column;
	} res_t;

	typedef struct packed {
		res_t [MAX_RES-1:0] res;
		logic [1:0]         cnt;
	} bundle_t;

	function automatic res_t mk_res(ev_t ev, logic [4:0] tt, logic [7:0] val, err_t err,
			logic [POS_OUT_BITS-1:0] line, logic [POS_OUT_BITS-1:0] column);
		res_t r;
		r.ev         = ev;
		r.token_type = tt;
		r.value_byte = val;
		r.err        = err;
		r.line       = line;
		r.column     = column;
		return r;
	endfunction

	// operator token type, zero when the character is no operator
	function automatic logic [4:0] op_type(logic [7:0] c);
		logic [4:0] t;
		case (c)
			"=":     t = TT_OP_BASE;
			"+":     t = TT_OP_BASE + 5'd1;
			"-":     t = TT_OP_BASE + 5'd2;
			"*":     t = TT_OP_BASE + 5'd3;
			"/":     t = TT_OP_BASE + 5'd4;
			"(":     t = TT_OP_BASE + 5'd5;
			")":     t = TT_OP_BASE + 5'd6;
			"{":     t = TT_OP_BASE + 5'd7;
			"}":     t = TT_OP_BASE + 5'd8;
			"%":     t = TT_OP_BASE + 5'd9;
			">":     t = TT_OP_BASE + 5'd10;
			"<":     t = TT_OP_BASE + 5'd11;
			",":     t = TT_OP_BASE + 5'd12;
			default: t = TT_IDENT;
		endcase
		return t;
	endfunction

	// keyword lookup over the kept prefix; longer identifiers match nothing
	function automatic logic [4:0] kw_type(kw_prefix_t p, logic [2:0] len);
		logic [4:0] t;
		t = TT_IDENT;
		case (len)
			3'd2: begin
				if ({p[0], p[1]} == "if") t = TT_IF;
				else if ({p[0], p[1]} == "fn") t = TT_FN;
			end
			3'd3: begin
				if ({p[0], p[1], p[2]} == "let") t = TT_LET;
				else if ({p[0], p[1], p[2]} == "use") t = TT_USE;
			end
			3'd4: begin
				if ({p[0], p[1], p[2], p[3]} == "elif") t = TT_ELIF;
				else if ({p[0], p[1], p[2], p[3]} == "else") t = TT_ELSE;
				else if ({p[0], p[1], p[2], p[3]} == "true") t = TT_BOOL;
				else if ({p[0], p[1], p[2], p[3]} == "null") t = TT_NULL;
			end
			3'd5: begin
				if ({p[0], p[1], p[2], p[3], p[4]} == "false") t = TT_BOOL;
				else if ({p[0], p[1], p[2], p[3], p[4]} == "while") t = TT_LOOP;
			end
			default: t = TT_IDENT;
		endcase
		return t;
	endfunction

endpackage

/* rtl/core/stok_step.sv */
// stok_step: tokenizer state (mode, keyword prefix, positions) and the
// single-pass logic that turns one character into a bundle of up to three results
// depends on stok_pkg
module stok_step #(
	parameter int LINE_BITS   = stok_pkg::LINE_BITS_DEF,
	parameter int COLUMN_BITS = stok_pkg::COLUMN_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  logic [7:0]        ch,
	output stok_pkg::bundle_t bundle
);
	import stok_pkg::*;

	mode_t                  mode_q, mode_d;
	kw_prefix_t             prefix_q, prefix_d;
	logic [2:0]             len_q, len_d;
	logic [LINE_BITS-1:0]   cur_line_q, start_line_q;
	logic [COLUMN_BITS-1:0] cur_col_q, start_col_q;

	logic [POS_OUT_BITS-1:0] cur_line_o, cur_col_o, st_line_o, st_col_o;

	logic       is_alpha, is_digit, is_space, is_zero, is_nl, is_quote, is_bslash;
	logic       is_op, ident_cont, esc_ok;
	logic [4:0] op_tt;
	logic [7:0] esc_val;

	mode_t      idle_mode;
	logic       idle_start;
	res_t [1:0] idle_res;
	logic [1:0] idle_cnt;

	logic take_idle, adv;

	assign is_alpha   = (ch inside {["a":"z"], ["A":"Z"]});
	assign is_digit   = (ch inside {["0":"9"]});
	assign is_space   = (ch == " ") || (ch inside {[8'd9:8'd13]});
	assign is_zero    = (ch == 8'd0);
	assign is_nl      = (ch == 8'd10);
	assign is_quote   = (ch == "\"");
	assign is_bslash  = (ch == "\\");
	assign op_tt      = op_type(ch);
	assign is_op      = (op_tt != TT_IDENT);
	assign ident_cont = is_alpha || is_digit || (ch == "_");
	assign esc_ok     = (ch == "n") || (ch == "t") || is_quote || is_bslash;
	assign esc_val    = (ch == "n") ? 8'd10 : ((ch == "t") ? 8'd9 : ch);

	// positions go out saturated to the port width
	if (LINE_BITS > POS_OUT_BITS) begin : g_line_wide
		assign cur_line_o = (|cur_line_q[LINE_BITS-1:POS_OUT_BITS]) ? '1
			: cur_line_q[POS_OUT_BITS-1:0];
		assign st_line_o = (|start_line_q[LINE_BITS-1:POS_OUT_BITS]) ? '1
			: start_line_q[POS_OUT_BITS-1:0];
	end else begin : g_line_narrow
		assign cur_line_o = POS_OUT_BITS'(cur_line_q);
		assign st_line_o  = POS_OUT_BITS'(start_line_q);
	end

	if (COLUMN_BITS > POS_OUT_BITS) begin : g_col_wide
		assign cur_col_o = (|cur_col_q[COLUMN_BITS-1:POS_OUT_BITS]) ? '1
			: cur_col_q[POS_OUT_BITS-1:0];
		assign st_col_o = (|start_col_q[COLUMN_BITS-1:POS_OUT_BITS]) ? '1
			: start_col_q[POS_OUT_BITS-1:0];
	end else begin : g_col_narrow
		assign cur_col_o = POS_OUT_BITS'(cur_col_q);
		assign st_col_o  = POS_OUT_BITS'(start_col_q);
	end

	// what a character does when seen between tokens
	always_comb begin
		idle_res   = '0;
		idle_cnt   = 2'd0;
		idle_mode  = MODE_IDLE;
		idle_start = !is_zero && !is_space;
		if (is_zero) begin
			idle_res[0] = mk_res(EV_END, TT_IDENT, 8'd0, ERR_NONE, cur_line_o, cur_col_o);
			idle_cnt    = 2'd1;
		end else if (is_space) begin
			idle_mode = MODE_IDLE;
		end else if (is_alpha) begin
			idle_mode   = MODE_IDENT;
			idle_res[0] = mk_res(EV_VALUE, TT_IDENT, ch, ERR_NONE, cur_line_o, cur_col_o);
			idle_cnt    = 2'd1;
		end else if (is_digit) begin
			idle_mode   = MODE_NUMBER;
			idle_res[0] = mk_res(EV_VALUE, TT_NUM, ch, ERR_NONE, cur_line_o, cur_col_o);
			idle_cnt    = 2'd1;
		end else if (is_quote) begin
			idle_mode = MODE_STRING;
		end else if (is_op) begin
			idle_res[0] = mk_res(EV_VALUE, op_tt, ch, ERR_NONE, cur_line_o, cur_col_o);
			idle_res[1] = mk_res(EV_DONE, op_tt, 8'd0, ERR_NONE, cur_line_o, cur_col_o);
			idle_cnt    = 2'd2;
		end else begin
			idle_mode   = MODE_HALT;
			idle_res[0] = mk_res(EV_ERROR, TT_IDENT, ch, ERR_UNKNOWN, cur_line_o, cur_col_o);
			idle_cnt    = 2'd1;
		end
	end

	// next state
	always_comb begin
		mode_d    = mode_q;
		prefix_d  = prefix_q;
		len_d     = len_q;
		take_idle = 1'b0;
		case (mode_q)
			MODE_IDENT: begin
				if (ident_cont) begin
					if (len_q < 3'd5) prefix_d[len_q] = ch;
					if (len_q < 3'd6) len_d = len_q + 3'd1;
				end else begin
					take_idle = 1'b1;
				end
			end
			MODE_NUMBER: begin
				if (!is_digit) take_idle = 1'b1;
			end
			MODE_STRING: begin
				if (is_zero) mode_d = MODE_HALT;
				else if (is_quote) mode_d = MODE_IDLE;
				else if (is_bslash) mode_d = MODE_ESCAPE;
			end
			MODE_ESCAPE: begin
				if (!is_zero && esc_ok) mode_d = MODE_STRING;
				else mode_d = MODE_HALT;
			end
			MODE_HALT: mode_d = MODE_HALT;
			default: take_idle = 1'b1;
		endcase
		if (take_idle) begin
			mode_d = idle_mode;
			if (is_alpha) begin
				prefix_d[0] = ch;
				len_d       = 3'd1;
			end
		end
	end

	assign adv = !is_zero && (mode_d != MODE_HALT);

	// results
	always_comb begin
		bundle = '0;
		case (mode_q)
			MODE_IDENT: begin
				if (ident_cont) begin
					bundle.res[0] = mk_res(EV_VALUE, TT_IDENT, ch, ERR_NONE, st_line_o, st_col_o);
					bundle.cnt    = 2'd1;
				end else begin
					bundle.res[0] = mk_res(EV_DONE, kw_type(prefix_q, len_q), 8'd0, ERR_NONE,
						st_line_o, st_col_o);
					bundle.res[1] = idle_res[0];
					bundle.res[2] = idle_res[1];
					bundle.cnt    = idle_cnt + 2'd1;
				end
			end
			MODE_NUMBER: begin
				if (is_digit) begin
					bundle.res[0] = mk_res(EV_VALUE, TT_NUM, ch, ERR_NONE, st_line_o, st_col_o);
					bundle.cnt    = 2'd1;
				end else begin
					bundle.res[0] = mk_res(EV_DONE, TT_NUM, 8'd0, ERR_NONE, st_line_o, st_col_o);
					bundle.res[1] = idle_res[0];
					bundle.res[2] = idle_res[1];
					bundle.cnt    = idle_cnt + 2'd1;
				end
			end
			MODE_STRING: begin
				if (is_zero) begin
					bundle.res[0] = mk_res(EV_ERROR, TT_IDENT, ch, ERR_UNTERM, cur_line_o, cur_col_o);
					bundle.cnt    = 2'd1;
				end else if (is_quote) begin
					bundle.res[0] = mk_res(EV_DONE, TT_STR, 8'd0, ERR_NONE, st_line_o, st_col_o);
					bundle.cnt    = 2'd1;
				end else if (!is_bslash && !is_nl) begin
					// newline inside a string is dropped from the value
					bundle.res[0] = mk_res(EV_VALUE, TT_STR, ch, ERR_NONE, st_line_o, st_col_o);
					bundle.cnt    = 2'd1;
				end
			end
			MODE_ESCAPE: begin
				if (is_zero) begin
					bundle.res[0] = mk_res(EV_ERROR, TT_IDENT, ch, ERR_END_ESC, cur_line_o, cur_col_o);
				end else if (esc_ok) begin
					bundle.res[0] = mk_res(EV_VALUE, TT_STR, esc_val, ERR_NONE,
						st_line_o, st_col_o);
				end else begin
					bundle.res[0] = mk_res(EV_ERROR, TT_IDENT, ch, ERR_BAD_ESC, cur_line_o, cur_col_o);
				end
				bundle.cnt = 2'd1;
			end
			MODE_HALT: bundle.cnt = 2'd0;
			default: begin
				bundle.res[0] = idle_res[0];
				bundle.res[1] = idle_res[1];
				bundle.cnt    = idle_cnt;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_IDLE;
			len_q        <= 3'd0;
			cur_line_q   <= '0;
			cur_col_q    <= '0;
			start_line_q <= '0;
			start_col_q  <= '0;
		end else if (fire) begin
			mode_q <= mode_d;
			len_q  <= len_d;
			if (take_idle && idle_start) begin
				start_line_q <= cur_line_q;
				start_col_q  <= cur_col_q;
			end
			if (adv) begin
				if (is_nl) begin
					if (cur_line_q != '1) cur_line_q <= cur_line_q + 1'b1;
					cur_col_q <= '0;
				end else if (cur_col_q != '1) begin
					cur_col_q <= cur_col_q + 1'b1;
				end
			end
		end
	end

	// keyword prefix only ever read where the current identifier wrote it
	always_ff @(posedge clk) begin
		if (fire) prefix_q <= prefix_d;
	end

endmodule

/* rtl/core/stok_outq.sv */
// stok_outq: result register holding one bundle and handing its results out
// one per cycle while out_ready is high on the output handshake; depends on stok_pkg
module stok_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  stok_pkg::bundle_t bundle_in,
	input  logic              out_ready,
	output logic              out_valid,
	output stok_pkg::res_t    res,
	output logic              last,
	output logic              free
);
	import stok_pkg::*;

	res_t [MAX_RES-1:0] res_q;
	logic [1:0]         cnt_q;
	logic [1:0]         idx_q;

	assign out_valid = (cnt_q != 2'd0);
	assign last      = (idx_q == cnt_q - 2'd1);
	assign res       = res_q[idx_q];
	// free when empty or once the final result of the held bundle leaves
	assign free      = !out_valid || (out_ready && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			idx_q <= 2'd0;
		end else if (load) begin
			cnt_q <= bundle_in.cnt;
			idx_q <= 2'd0;
		end else if (out_valid && out_ready) begin
			if (last) cnt_q <= 2'd0;
			else idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) res_q <= bundle_in.res;
	end

endmodule

/* rtl/core/source_tokenizer_core.sv */
// source_tokenizer_core: top level of the streaming tokenizer
// input register, stok_step (state and result logic), stok_outq (result register)
// depends on stok_pkg
//
//  channel  signals                  direction  payload
//  in       in_valid / in_ready      into block ch
//  out      out_valid / out_ready    from block event_res token_type value_byte
//                                               error_code token_line token_column last
//
// a character is taken into the input register, then decoded
// against the mode and keyword prefix into a bundle of zero to three results
// results leave one per cycle while out_ready is high, and the result register is the limit;
// whitespace between tokens and opening quotes give no results and never wait for it
// arst_n clears mode, identifier length and all position counters
// out_ready low holds the bundle and backs up in_ready once the input register holds a character with results
module source_tokenizer_core #(
	parameter int LINE_BITS   = stok_pkg::LINE_BITS_DEF,
	parameter int COLUMN_BITS = stok_pkg::COLUMN_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  ch,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  event_res,
	output logic [4:0]  token_type,
	output logic [7:0]  value_byte,
	output logic [2:0]  error_code,
	output logic [15:0] token_line,
	output logic [15:0] token_column,
	output logic        last
);
	import stok_pkg::*;

	logic [7:0] ch_s1;
	logic       vld_s1;
	logic       proc, load, free;
	bundle_t    bundle;
	res_t       res;

	// a character with no results never waits for the result register
	assign proc     = vld_s1 && (free || (bundle.cnt == 2'd0));
	assign load     = proc && (bundle.cnt != 2'd0);
	assign in_ready = !vld_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			vld_s1 <= 1'b1;
		end else if (proc) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) ch_s1 <= ch;
	end

	stok_step #(
		.LINE_BITS   (LINE_BITS),
		.COLUMN_BITS (COLUMN_BITS)
	) u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (proc),
		.ch     (ch_s1),
		.bundle (bundle)
	);

	stok_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.bundle_in (bundle),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.res       (res),
		.last      (last),
		.free      (free)
	);

	assign event_res    = res.ev;
	assign token_type   = res.token_type;
	assign value_byte   = res.value_byte;
	assign error_code   = res.err;
	assign token_line   = res.line;
	assign token_column = res.column;

`ifndef NO_ASSERTIONS
	// an error halts the block, nothing follows it
	a_halt_after_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && (event_res == EV_ERROR) |=> !out_valid)
		else $error("result after error");

	a_error_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_res == EV_ERROR) |-> last)
		else $error("error not last of its bundle");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_res == EV_END) |-> last && (value_byte == 8'd0))
		else $error("end of input not last or carries a value");

	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_res == EV_DONE) |-> (value_byte == 8'd0) && (error_code == ERR_NONE))
		else $error("token done carries value or error");
`endif

endmodule
